// ----- rtl/panel_weighted_demean_assert.svh -----
// Assertion macros for the panel weighted demean block.
`ifndef PANEL_WEIGHTED_DEMEAN_ASSERT_SVH
`define PANEL_WEIGHTED_DEMEAN_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define PWD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define PWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pwd_pkg.sv -----
// Types and constants for the panel weighted demean block.
`default_nettype none

package pwd_pkg;

    localparam int VAL_W  = 32;
    localparam int WGT_W  = 16;
    localparam int PROD_W = VAL_W + WGT_W + 1;
    localparam int SUM_W  = 54;
    localparam int WT_W   = 22;
    localparam int DIV_CNT_W = 6;

    localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample_value;
        logic [WGT_W-1:0]        sample_weight;
        logic                    last_in_panel;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] centered_value;
        logic                    last_of_run;
        logic                    zero_weight_flag;
        logic                    overflow_flag;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/panel_weighted_demean.sv -----
// Panel weighted demean: stores a panel, divides out its weighted mean, emits centered values.
//
// Usage: a request (value, weight, last mark) is taken on a clock edge where start is
// high and busy is low. While a panel is open, requests are taken every cycle that
// start is high and produce no result. The request marked last_in_panel, or the
// PANEL_MAX-th request, closes the panel and raises busy. The block then adds the final
// product, prepares the divide, runs a restoring divider one quotient bit per cycle,
// forms the mean and reads the panel memory once per cycle, one entry for each of the
// n samples in the panel. Results come out on o_result, one per cycle with
// o_result_valid high for that cycle; each memory read passes through r_rd_data and then
// the o_result register. The receiver cannot stall. Busy drops in the cycle after the
// last read is issued. Synchronous active-low reset empties the panel and clears all
// control state; the memory itself is not cleared, only entries written in the current
// panel are read.
`default_nettype none

module panel_weighted_demean #(
    parameter int PANEL_MAX = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  pwd_pkg::t_req    i_req,
    output logic             busy,
    output logic             o_result_valid,
    output pwd_pkg::t_result o_result
);
    import pwd_pkg::*;

    localparam int AW = (PANEL_MAX > 1) ? $clog2(PANEL_MAX) : 1;
    localparam int CW = $clog2(PANEL_MAX + 1);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [VAL_W-1:0] r_mem [PANEL_MAX];

    logic [2:0]                r_state;
    logic [AW-1:0]             r_count;
    logic [WT_W-1:0]           r_wt;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_prod_vld;
    logic signed [PROD_W-1:0]  r_prod;
    logic [CW-1:0]             r_n;
    logic                      r_ovf;
    logic                      r_zero;
    logic                      r_neg;
    logic [SUM_W-1:0]          r_dvd;
    logic [WT_W-1:0]           r_rem;
    logic [DIV_CNT_W-1:0]      r_bit;
    logic [VAL_W-1:0]          r_mean;
    logic [AW-1:0]             r_rd_idx;
    logic                      r_rd_vld;
    logic                      r_rd_last;
    logic [VAL_W-1:0]          r_rd_data;

    logic                      w_accept;
    logic [CW-1:0]             w_count_inc;
    logic                      w_full;
    logic                      w_close;
    logic [CW-1:0]             w_rd_inc;
    logic                      w_rd_done;
    logic signed [PROD_W-1:0]  w_prod;
    logic [SUM_W-1:0]          w_abs;
    logic [WT_W:0]             w_rem_sh;
    logic [WT_W+1:0]           w_trial;
    logic [SUM_W-1:0]          w_q;
    logic [VAL_W:0]            w_diff;
    logic [VAL_W-1:0]          w_sat;

    assign busy        = (r_state != S_LOAD);
    assign w_accept    = start && !busy;
    assign w_count_inc = {{(CW-AW){1'b0}}, r_count} + CW'(1);
    assign w_full      = (w_count_inc == CW'(PANEL_MAX));
    assign w_close     = i_req.last_in_panel || w_full;
    assign w_rd_inc    = {{(CW-AW){1'b0}}, r_rd_idx} + CW'(1);
    assign w_rd_done   = (w_rd_inc == r_n);

    assign w_prod = $signed(i_req.sample_value) * $signed({1'b0, i_req.sample_weight});

    assign w_abs = r_sum[SUM_W-1] ? (SUM_W'(0) - $unsigned(r_sum)) : $unsigned(r_sum);

    // shift one dividend bit into the partial remainder and trial-subtract
    assign w_rem_sh = {r_rem, r_dvd[SUM_W-1]};
    assign w_trial  = {1'b0, w_rem_sh} - {2'b00, r_wt};

    assign w_q = r_neg ? (SUM_W'(0) - r_dvd) : r_dvd;

    assign w_diff = {r_rd_data[VAL_W-1], r_rd_data} - {r_mean[VAL_W-1], r_mean};
    assign w_sat  = (w_diff[VAL_W] != w_diff[VAL_W-1])
                  ? (w_diff[VAL_W] ? SAT_MIN : SAT_MAX)
                  : w_diff[VAL_W-1:0];

    // panel memory: write on accept, read during emit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_count] <= i_req.sample_value;
        end
        if (r_state == S_EMIT) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_count        <= '0;
            r_wt           <= '0;
            r_sum          <= '0;
            r_prod_vld     <= 1'b0;
            r_bit          <= '0;
            r_rd_idx       <= '0;
            r_rd_vld       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_prod_vld     <= w_accept;
            r_rd_vld       <= (r_state == S_EMIT);
            o_result_valid <= r_rd_vld;
            if (r_prod_vld) begin
                r_sum <= r_sum + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            end
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        r_wt <= r_wt + {{(WT_W-WGT_W){1'b0}}, i_req.sample_weight};
                        if (w_close) begin
                            r_count <= '0;
                            r_state <= S_ACC;
                        end else begin
                            r_count <= w_count_inc[AW-1:0];
                        end
                    end
                end
                S_ACC: begin
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_bit   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_bit <= r_bit + DIV_CNT_W'(1);
                    if (r_bit == DIV_CNT_W'(SUM_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_rd_idx <= '0;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    r_rd_idx <= w_rd_inc[AW-1:0];
                    if (w_rd_done) begin
                        r_sum   <= '0;
                        r_wt    <= '0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod <= w_prod;
            if (w_close) begin
                r_n   <= w_count_inc;
                r_ovf <= w_full && !i_req.last_in_panel;
            end
        end
        case (r_state)
            S_SETUP: begin
                r_neg  <= r_sum[SUM_W-1];
                r_dvd  <= w_abs;
                r_rem  <= '0;
                r_zero <= (r_wt == '0);
            end
            S_DIV: begin
                if (!w_trial[WT_W+1]) begin
                    r_rem <= w_trial[WT_W-1:0];
                    r_dvd <= {r_dvd[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[WT_W-1:0];
                    r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
                end
            end
            S_FIN: begin
                r_mean <= r_zero ? '0 : w_q[VAL_W-1:0];
            end
            default: begin
            end
        endcase
        r_rd_last                 <= w_rd_done;
        o_result.centered_value   <= w_sat;
        o_result.last_of_run      <= r_rd_last;
        o_result.zero_weight_flag <= r_zero;
        o_result.overflow_flag    <= r_ovf;
    end

`include "panel_weighted_demean_assert.svh"

    `PWD_ASSERT_NOW(a_rem_bound, r_state == S_DIV && r_wt != '0, r_rem < r_wt, "remainder too big")
    `PWD_ASSERT_NEXT(a_gap, o_result_valid && o_result.last_of_run, !o_result_valid, "late result")
    `PWD_ASSERT_NOW(a_count_cap, r_state == S_LOAD, int'(r_count) < PANEL_MAX, "count overflow")

endmodule

`default_nettype wire

// ----- dv/pwd_checker.sv -----
// Checker for the panel weighted demean block: predicts centered results and compares them.
`timescale 1ns / 1ps

module pwd_checker #(
    parameter int PANEL_MAX = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire               i_busy,
    input  pwd_pkg::t_req     i_req,
    input  wire               i_result_valid,
    input  pwd_pkg::t_result  i_result,
    output int                o_fail_count,
    output int                o_pending
);
    import pwd_pkg::*;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic signed [VAL_W-1:0] panel_vals [PANEL_MAX];
    int                      panel_len = 0;
    longint                  wsum_acc = 0;
    longint                  wtotal_acc = 0;
    t_result                 centered_q [$];
    int                      errors = 0;

    // Fold one accepted request into the panel; on close, queue every centered value.
    task automatic absorb_sample(input t_req r);
        longint  weight_ext;
        longint  mean;
        longint  diff;
        bit      full;
        t_result res;
        weight_ext = r.sample_weight;
        panel_vals[panel_len] = r.sample_value;
        wsum_acc   += r.sample_value * weight_ext;
        wtotal_acc += weight_ext;
        panel_len++;
        full = (panel_len >= PANEL_MAX);
        if (r.last_in_panel || full) begin
            // truncate toward zero; an empty weight total forces the mean to zero
            mean = (wtotal_acc == 0) ? 64'sd0 : wsum_acc / wtotal_acc;
            for (int i = 0; i < panel_len; i++) begin
                diff = panel_vals[i] - mean;
                if (diff > SAT_HI) diff = SAT_HI;
                if (diff < SAT_LO) diff = SAT_LO;
                res.centered_value   = diff[VAL_W-1:0];
                res.last_of_run      = (i == panel_len - 1);
                res.zero_weight_flag = (wtotal_acc == 0);
                res.overflow_flag    = full && !r.last_in_panel;
                centered_q.push_back(res);
            end
            panel_len  = 0;
            wsum_acc   = 0;
            wtotal_acc = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            panel_len  = 0;
            wsum_acc   = 0;
            wtotal_acc = 0;
            centered_q.delete();
        end else begin
            // compare first: a result never belongs to a panel closing on this edge
            if (i_result_valid) begin
                if (centered_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, got %h", $time, i_result);
                end else begin
                    want = centered_q.pop_front();
                    if (i_result.centered_value !== want.centered_value) begin
                        errors++;
                        $display("%0t: centered_value expected %h got %h", $time,
                                 want.centered_value, i_result.centered_value);
                    end
                    if (i_result.last_of_run !== want.last_of_run) begin
                        errors++;
                        $display("%0t: last_of_run expected %b got %b", $time,
                                 want.last_of_run, i_result.last_of_run);
                    end
                    if (i_result.zero_weight_flag !== want.zero_weight_flag) begin
                        errors++;
                        $display("%0t: zero_weight_flag expected %b got %b", $time,
                                 want.zero_weight_flag, i_result.zero_weight_flag);
                    end
                    if (i_result.overflow_flag !== want.overflow_flag) begin
                        errors++;
                        $display("%0t: overflow_flag expected %b got %b", $time,
                                 want.overflow_flag, i_result.overflow_flag);
                    end
                end
            end
            if (i_start && !i_busy) begin
                absorb_sample(i_req);
            end
        end
        o_fail_count <= errors;
        o_pending    <= centered_q.size();
    end

endmodule

// ----- dv/tb_panel_weighted_demean.sv -----
// Testbench top for the panel weighted demean block: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_panel_weighted_demean;
    import pwd_pkg::*;

    localparam int PANEL_MAX    = 64;
    localparam int RANDOM_ITEMS = 180;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_req    i_req = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;
    int      fail_count;
    int      pending;

    int      burst_left = 0;
    bit      steady = 1'b0;

    always #6 i_clk = ~i_clk;

    panel_weighted_demean #(
        .PANEL_MAX(PANEL_MAX)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_req          (i_req),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    pwd_checker #(
        .PANEL_MAX(PANEL_MAX)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req          (i_req),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Hold the request until an edge sees busy low.
    task automatic send_request(input logic [VAL_W-1:0] value, input logic [WGT_W-1:0] weight,
                                input logic mark);
        int gap;
        if (burst_left == 0) begin
            // switch now and then between steady streaming and bursty traffic
            if ($urandom_range(0, 7) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        i_req <= '{sample_value: value, sample_weight: weight, last_in_panel: mark};
        do @(posedge i_clk); while (busy);
    endtask

    // Pause the sender until every expected result has come back.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          sent;
        int          panel_idx;
        int          len;
        bit          zero_panel;
        bit          end_mark;
        logic [31:0] value;
        logic [15:0] weight;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single sample at weight 16'h8000: mean equals the value
        send_request(32'h7FFF_FFFF, 16'h8000, 1'b1);
        // mean at the negative extreme: first value saturates high
        send_request(32'h7FFF_FFFF, 16'h0000, 1'b0);
        send_request(32'h8000_0000, 16'hFFFF, 1'b1);
        // mean at the positive extreme: first value saturates low
        send_request(32'h8000_0000, 16'h0000, 1'b0);
        send_request(32'h7FFF_FFFF, 16'h0001, 1'b1);
        // all weights zero: mean forced to zero and flagged
        send_request(32'h1234_5678, 16'h0000, 1'b0);
        send_request(32'hFFFF_FFFB, 16'h0000, 1'b0);
        send_request(32'h0000_0000, 16'h0000, 1'b1);
        // truncation toward zero, negative then positive
        send_request(32'hFFFF_FFF9, 16'h0001, 1'b0);
        send_request(32'h0000_0000, 16'h0001, 1'b1);
        send_request(32'h0000_0007, 16'h0001, 1'b0);
        send_request(32'h0000_0000, 16'h0001, 1'b1);
        // alternating bit patterns across value and weight, then all-ones and zero values
        send_request(32'hAAAA_AAAA, 16'h5555, 1'b0);
        send_request(32'h5555_5555, 16'hAAAA, 1'b0);
        send_request(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_request(32'h0000_0000, 16'h0001, 1'b1);
        send_request(32'h0000_0000, 16'hFFFF, 1'b1);
        drain();

        sent      = 0;
        panel_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            end_mark = 1'b1;
            if (panel_idx == 2) begin
                // fill to capacity with no last mark
                len      = PANEL_MAX;
                end_mark = 1'b0;
            end else if (panel_idx == 6) begin
                len = PANEL_MAX;
            end else if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(7, 20);
            end else begin
                len = $urandom_range(1, 6);
            end
            zero_panel = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 7))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = $urandom_range(0, 2047) - 1024;
                    default: value = $urandom;
                endcase
                case ($urandom_range(0, 7))
                    0:       weight = 16'h0000;
                    1:       weight = 16'h8000;
                    2:       weight = 16'hFFFF;
                    3:       weight = 16'h0001;
                    default: weight = $urandom_range(0, 65535);
                endcase
                if (zero_panel) weight = 16'h0000;
                send_request(value, weight, (i == len - 1) ? end_mark : 1'b0);
            end
            sent += len;
            panel_idx++;
            if (panel_idx == 10) drain();
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
